### sv/four_digit_seven_segment_scan_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-digit seven-segment scan core
// Shared shorthand for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define FDSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge, quiet during reset.
`define FDSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/fdss_pkg.sv
// ----------------------------------------------------------------------------
// fdss_pkg
// Types, constants and helper functions of the seven-segment scan core.
// ----------------------------------------------------------------------------
package fdss_pkg;

	localparam int unsigned ValueW = 14;
	localparam int unsigned DigitW = 4;
	localparam int unsigned SegW   = 7;
	localparam int unsigned PosW   = 2;
	localparam int unsigned NumDigits = 4;

	localparam logic [ValueW-1:0] MaxShown = 14'd9999;

	// One value after conversion, as handed to the frame serialiser.
	typedef struct packed {
		logic                                oor;
		logic [PosW-1:0]                     last_idx;
		logic [NumDigits-1:0][DigitW-1:0]    digits;
	} item_t;

	// Result of taking one decimal digit off the top of a value.
	typedef struct packed {
		logic [DigitW-1:0] digit;
		logic [ValueW-1:0] rest;
	} split_t;

	// Finds the largest k in 0..9 with k*weight not above x, by comparing against all
	// nine multiples at once, and returns k with the remainder x - k*weight.
	function automatic split_t digit_split(logic [ValueW-1:0] x, logic [ValueW-1:0] weight);
		split_t           res;
		logic [ValueW+2:0] thr;
		res.digit = '0;
		res.rest  = x;
		for (int k = 1; k <= 9; k++) begin
			thr = (ValueW+3)'(k) * {3'b000, weight};
			if ({3'b000, x} >= thr) begin
				res.digit = DigitW'(k);
				res.rest  = x - thr[ValueW-1:0];
			end
		end
		return res;
	endfunction

	// Segment pattern, bit 0 is segment a and bit 6 is segment g.
	function automatic logic [SegW-1:0] seg_of(logic [DigitW-1:0] d);
		logic [SegW-1:0] s;
		unique case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

### sv/four_digit_seven_segment_scan_core.sv
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scan_core
// Splits a binary value into decimal digits and emits seven-segment scan frames.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+----------------------------------
//  in      | into core | in_valid / in_stall | value (14 bits)
//  out     | from core | out_valid/out_stall | position, digit, segments, flags
//
//  A value passes four conversion stages and the frame serialiser before its first
//  frame appears. The serialiser sends one frame per cycle while the output is not
//  stalled, one to four frames per value, and takes the next value in the cycle that
//  its last frame is loaded, so back-to-back values leave no gap between frames.
//  Reset clears every valid flag and the frame index; payload registers are not
//  reset. A stall on the output holds the frame and backs up through the stages.
//
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scan_core
	import fdss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ValueW-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PosW-1:0]   digit_position,
	output logic [DigitW-1:0] digit_value,
	output logic [SegW-1:0]   segments,
	output logic              out_of_range,
	output logic              last_frame
);

	// Converted value travelling from the last conversion stage to the serialiser.
	logic  item_valid;
	logic  item_stall;
	item_t item;

	// Conversion pipeline: range check, frame count and thousands in the second
	// stage, then hundreds and finally tens with units, each by nine parallel
	// compares against the multiples of the digit weight.
	fdss_bcd_pipe u_bcd_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item)
	);

	// Frame serialiser: walks the digits from the rightmost one and marks the last
	// frame. An out-of-range value yields a single blank frame with its flag set.
	fdss_frame_ser u_frame_ser (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_position (digit_position),
		.digit_value    (digit_value),
		.segments       (segments),
		.out_of_range   (out_of_range),
		.last_frame     (last_frame)
	);

endmodule

### sv/fdss_bcd_pipe.sv
// ----------------------------------------------------------------------------
// fdss_bcd_pipe
// Four-stage binary to decimal conversion: an input register, then thousands,
// hundreds, and finally tens with units.
// ----------------------------------------------------------------------------
module fdss_bcd_pipe
	import fdss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ValueW-1:0] value,
	output logic              item_valid,
	input  logic              item_stall,
	output item_t             item
);

	logic adv1, adv2, adv3, adv4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [ValueW-1:0]  val_s1;

	logic               oor_s2;
	logic [PosW-1:0]    last_s2;
	logic [DigitW-1:0]  d3_s2;
	logic [9:0]         rem_s2;

	logic               oor_s3;
	logic [PosW-1:0]    last_s3;
	logic [DigitW-1:0]  d3_s3, d2_s3;
	logic [6:0]         rem_s3;

	logic               oor_s4;
	logic [PosW-1:0]    last_s4;
	logic [DigitW-1:0]  d3_s4, d2_s4, d1_s4, d0_s4;

	split_t             sp2, sp3, sp4;
	logic               oor_c;
	logic [PosW-1:0]    last_c;

	// A stage moves on when it is empty or the one after it moves.
	assign adv4     = !v_s4 || !item_stall;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_comb begin
		oor_c = (val_s1 > MaxShown);
		if (val_s1 >= 14'd1000) begin
			last_c = 2'd3;
		end else if (val_s1 >= 14'd100) begin
			last_c = 2'd2;
		end else if (val_s1 >= 14'd10) begin
			last_c = 2'd1;
		end else begin
			last_c = 2'd0;
		end
		sp2 = digit_split(val_s1, 14'd1000);
		sp3 = digit_split({4'b0000, rem_s2}, 14'd100);
		sp4 = digit_split({7'b0000000, rem_s3}, 14'd10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			val_s1 <= value;
		end
		if (adv2 && v_s1) begin
			oor_s2  <= oor_c;
			last_s2 <= last_c;
			d3_s2   <= sp2.digit;
			rem_s2  <= sp2.rest[9:0];
		end
		if (adv3 && v_s2) begin
			oor_s3  <= oor_s2;
			last_s3 <= last_s2;
			d3_s3   <= d3_s2;
			d2_s3   <= sp3.digit;
			rem_s3  <= sp3.rest[6:0];
		end
		if (adv4 && v_s3) begin
			oor_s4  <= oor_s3;
			last_s4 <= last_s3;
			d3_s4   <= d3_s3;
			d2_s4   <= d2_s3;
			d1_s4   <= sp4.digit;
			d0_s4   <= sp4.rest[3:0];
		end
	end

	assign item_valid    = v_s4;
	assign item.oor      = oor_s4;
	assign item.last_idx = last_s4;
	assign item.digits   = {d3_s4, d2_s4, d1_s4, d0_s4};

endmodule

### sv/fdss_frame_ser.sv
// ----------------------------------------------------------------------------
// fdss_frame_ser
// Turns one converted value into its scan frames and holds the output word.
// ----------------------------------------------------------------------------
module fdss_frame_ser
	import fdss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PosW-1:0]   digit_position,
	output logic [DigitW-1:0] digit_value,
	output logic [SegW-1:0]   segments,
	output logic              out_of_range,
	output logic              last_frame
);

	logic            busy_q;
	item_t           it_q;
	logic [PosW-1:0] idx_q;
	logic            out_valid_q;

	logic              load;
	logic              frame_last;
	logic              take_item;
	logic [DigitW-1:0] frame_digit;

	assign load        = !out_valid_q || !out_stall;
	assign frame_last  = it_q.oor || (idx_q == it_q.last_idx);
	assign take_item   = !busy_q || (load && frame_last);
	assign item_stall  = !take_item;
	assign frame_digit = it_q.oor ? '0 : it_q.digits[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= busy_q;
			end
			if (busy_q && load) begin
				idx_q <= frame_last ? '0 : idx_q + 2'd1;
			end
			if (take_item) begin
				busy_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_item && item_valid) begin
			it_q <= item;
		end
		if (load && busy_q) begin
			digit_position <= it_q.oor ? '0 : idx_q;
			digit_value    <= frame_digit;
			segments       <= it_q.oor ? '0 : seg_of(frame_digit);
			out_of_range   <= it_q.oor;
			last_frame     <= frame_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/fdss_port_chk.sv
// ----------------------------------------------------------------------------
// fdss_port_chk
// Port-level checks of the scan core, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_digit_seven_segment_scan_core_macros.svh"

module fdss_port_chk
	import fdss_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [ValueW-1:0] value,
	input logic              out_valid,
	input logic              out_stall,
	input logic [PosW-1:0]   digit_position,
	input logic [DigitW-1:0] digit_value,
	input logic [SegW-1:0]   segments,
	input logic              out_of_range,
	input logic              last_frame
);

	`FDSS_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(value),
		"input word changed while stalled")

	`FDSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(digit_position) && $stable(digit_value) &&
		$stable(segments) && $stable(last_frame),
		"output word changed while stalled")

	`FDSS_ASSERT_NOW(a_blank_frame, out_valid && out_of_range,
		last_frame && (segments == '0) && (digit_position == '0) && (digit_value == '0),
		"out-of-range frame is not a single blank frame")

	`FDSS_ASSERT_NOW(a_seg_match, out_valid && !out_of_range,
		(digit_value <= 4'd9) && (segments == seg_of(digit_value)),
		"segment pattern does not match the digit")

	`FDSS_ASSERT_NEXT(a_next_pos, out_valid && !out_stall && !last_frame,
		out_valid && !out_of_range &&
		(digit_position == PosW'($past(digit_position) + 2'd1)),
		"frame after a non-final frame is not the next digit")

endmodule

bind four_digit_seven_segment_scan_core fdss_port_chk u_port_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.value          (value),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.digit_position (digit_position),
	.digit_value    (digit_value),
	.segments       (segments),
	.out_of_range   (out_of_range),
	.last_frame     (last_frame)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the four-digit seven-segment scan core
// Sends values through the input channel with random gaps and stalls the frame
// channel at random, predicts every scan frame and checks each one as it leaves.
// ----------------------------------------------------------------------------
module testbench;
	import fdss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One scan frame as it leaves the core.
	typedef struct packed {
		logic [PosW-1:0]   pos;
		logic [DigitW-1:0] dig;
		logic [SegW-1:0]   seg;
		logic              oor;
		logic              last;
	} scan_frame_t;

	// One value waiting to be sent. The idle count is the gap that follows it, and
	// a drain mark holds the value back until every frame in flight has arrived.
	typedef struct {
		logic [ValueW-1:0] val;
		int unsigned       idle_after;
		bit                drain;
	} pending_word_t;

	// Segment patterns, bit 0 is segment a and bit 6 is segment g.
	localparam logic [SegW-1:0] GLYPH [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	localparam int unsigned ShownMax   = MaxShown;
	localparam int unsigned MaxMisShow = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ValueW-1:0] value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PosW-1:0]   digit_position;
	logic [DigitW-1:0] digit_value;
	logic [SegW-1:0]   segments;
	logic              out_of_range;
	logic              last_frame;

	pending_word_t words_to_send [$];
	scan_frame_t   frames_due [$];

	int unsigned total_words;
	int unsigned words_accepted;
	int unsigned frames_checked;
	int unsigned mismatches;
	int unsigned above_range_words;
	int unsigned words_by_width [5];

	// Driver state.
	int unsigned idle_left;
	int unsigned cur_idle;

	// Monitor state.
	int unsigned stall_left;
	int unsigned calm_left;
	scan_frame_t got_frame;
	scan_frame_t want_frame;

	four_digit_seven_segment_scan_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_position (digit_position),
		.digit_value    (digit_value),
		.segments       (segments),
		.out_of_range   (out_of_range),
		.last_frame     (last_frame)
	);

	always #10 clk = ~clk;

	// Pause length drawn from three ranges: mostly the shortest, now and then the longest.
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Works out the frames that one accepted word must produce and queues them.
	// Values above the display range give a single blank frame carrying the
	// out-of-range flag; otherwise leading zeros are blanked, so the frame count
	// follows the number of significant digits and zero still shows one digit.
	function automatic void expand_into_frames(input logic [ValueW-1:0] v);
		int unsigned n;
		int unsigned nfr;
		int unsigned dig [NumDigits];
		scan_frame_t f;
		n = 32'(v);
		if (n > ShownMax) begin
			f.pos  = '0;
			f.dig  = '0;
			f.seg  = '0;
			f.oor  = 1'b1;
			f.last = 1'b1;
			frames_due.push_back(f);
			above_range_words++;
			return;
		end
		dig[0] = n % 10;
		dig[1] = (n / 10) % 10;
		dig[2] = (n / 100) % 10;
		dig[3] = n / 1000;
		if (n >= 1000)
			nfr = 4;
		else if (n >= 100)
			nfr = 3;
		else if (n >= 10)
			nfr = 2;
		else
			nfr = 1;
		words_by_width[nfr]++;
		for (int k = 0; k < nfr; k++) begin
			f.pos  = PosW'(k);
			f.dig  = DigitW'(dig[k]);
			f.seg  = GLYPH[dig[k]];
			f.oor  = 1'b0;
			f.last = (k == nfr - 1);
			frames_due.push_back(f);
		end
	endfunction

	// Driver. A word is predicted at the edge that accepts it; the next one is put
	// on the port in the same step, so valid stays high across back-to-back words
	// and takes at most one assignment per edge. While stalled it holds the word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			value     <= '0;
			idle_left = 0;
			cur_idle  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expand_into_frames(value);
				words_accepted++;
				idle_left = cur_idle;
			end
			if (!in_valid || !in_stall) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (words_to_send.size() > 0 &&
						!(words_to_send[0].drain && frames_due.size() != 0)) begin
					in_valid <= 1'b1;
					value    <= words_to_send[0].val;
					cur_idle = words_to_send[0].idle_after;
					void'(words_to_send.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every accepted frame is checked against the oldest prediction; the
	// stall pattern mixes short and long holds with calm stretches of none.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			calm_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_frame.pos  = digit_position;
				got_frame.dig  = digit_value;
				got_frame.seg  = segments;
				got_frame.oor  = out_of_range;
				got_frame.last = last_frame;
				frames_checked++;
				if (frames_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxMisShow)
						$display("%0t: frame with nothing expected: pos %0d dig %0d seg %h oor %b last %b",
							$realtime, got_frame.pos, got_frame.dig, got_frame.seg,
							got_frame.oor, got_frame.last);
				end else begin
					want_frame = frames_due.pop_front();
					if (got_frame !== want_frame) begin
						mismatches++;
						if (mismatches <= MaxMisShow)
							$display("%0t: frame differs: pos %0d/%0d dig %0d/%0d seg %h/%h oor %b/%b last %b/%b (expected/actual)",
								$realtime, want_frame.pos, got_frame.pos,
								want_frame.dig, got_frame.dig,
								want_frame.seg, got_frame.seg,
								want_frame.oor, got_frame.oor,
								want_frame.last, got_frame.last);
					end
				end
			end
			if (calm_left > 0) begin
				calm_left--;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 299) == 0)
					calm_left = $urandom_range(100, 400);
				else if ($urandom_range(0, 3) == 0)
					stall_left = pick_pause();
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [ValueW-1:0] directed [] = '{
			14'd0, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000, 14'd9999,
			14'd10000, 14'd16383, 14'd1234, 14'd5678, 14'd1005, 14'd1001,
			14'd8192, 14'd8888, 14'd7, 14'd40, 14'd305, 14'd10001, 14'd12345
		};
		pending_word_t w;
		int unsigned   r;
		int unsigned   burst_left;

		// Directed words first: digit-count boundaries, the range edge, inner
		// zeros, every digit glyph and the all-zero and all-one patterns.
		foreach (directed[i]) begin
			w.val        = directed[i];
			w.idle_after = (i % 4 == 3) ? pick_pause() : 0;
			w.drain      = 1'b0;
			words_to_send.push_back(w);
		end

		// Random words, most of them in range, with runs of back-to-back traffic.
		burst_left = 0;
		for (int i = 0; i < 400; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				w.val = ValueW'($urandom_range(1000, 9999));
			else if (r < 50)
				w.val = ValueW'($urandom_range(100, 999));
			else if (r < 65)
				w.val = ValueW'($urandom_range(10, 99));
			else if (r < 75)
				w.val = ValueW'($urandom_range(0, 9));
			else if (r < 90)
				w.val = ValueW'($urandom_range(10000, 16383));
			else
				w.val = ValueW'($urandom_range(0, 16383));
			if (burst_left > 0) begin
				burst_left--;
				w.idle_after = 0;
			end else if ($urandom_range(0, 19) == 0) begin
				burst_left   = $urandom_range(10, 30);
				w.idle_after = 0;
			end else begin
				w.idle_after = $urandom_range(0, 1) ? 0 : pick_pause();
			end
			// The first random word waits for the core to empty, and a few more do.
			w.drain = (i == 0) || ($urandom_range(0, 59) == 0);
			words_to_send.push_back(w);
		end
		total_words = words_to_send.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (words_accepted != total_words)
			@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		// Let any stray frame show up before judging.
		repeat (30) @(posedge clk);
		if (frames_due.size() != 0)
			mismatches += frames_due.size();

		$display("Run covered %0d words (%0d above range) and %0d frames.",
			words_accepted, above_range_words, frames_checked);
		$display("Words by digit count: one %0d, two %0d, three %0d, four %0d.",
			words_by_width[1], words_by_width[2], words_by_width[3], words_by_width[4]);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatching frames.", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Timed out with %0d words accepted and %0d frames outstanding.",
			words_accepted, frames_due.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/fdss_pkg.sv
sv/fdss_bcd_pipe.sv
sv/fdss_frame_ser.sv
sv/four_digit_seven_segment_scan_core.sv
sv/fdss_port_chk.sv
bench/testbench.sv
